FILE: rtl/core/mvm_pkg.sv
package mvm_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RESET_COUNT = 13'd2048;

    // Defaults for the top level parameters
    localparam int DEFAULT_MAX_COLS = 4096;
    localparam int DEFAULT_MAX_ROWS = 4096;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;

    localparam int ROW_NUM_W = 12;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [47:0]    row_sum;
        logic [ROW_NUM_W-1:0]  row_number;
        logic                  last_row;
        logic signed [55:0]    running_checksum;
    } res_word_t;

    // One multiply-accumulate job handed from front to back
    typedef struct packed {
        logic signed [15:0]    value;
        logic signed [15:0]    vec;
        logic                  first;
        logic                  row_end;
        logic                  last_row;
        logic [ROW_NUM_W-1:0]  row_number;
    } mac_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/core/mvm_front.sv
module mvm_front #(
    parameter int MAX_COLS = mvm_pkg::DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = mvm_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  mvm_pkg::cmd_word_t            cmd_word,
    input  logic [$clog2(MAX_COLS+1)-1:0] cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
    input  mvm_pkg::fifo_status_t         fifo_status,
    output logic                          push,
    output mvm_pkg::mac_word_t            push_word
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int CNTW = $clog2(MAX_COLS+1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RNTW = $clog2(MAX_ROWS+1);

    logic signed [15:0] vec_mem [MAX_COLS];

    logic [CW-1:0]      col_reg, col_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               fresh_reg, fresh_next;
    logic               s1_valid_reg, s1_valid_next;
    mvm_pkg::mac_word_t s1_reg;
    logic signed [15:0] vec_reg;

    logic               accept;
    logic               is_load;
    logic               is_matrix;
    logic [CW-1:0]      col_eff;
    logic [CNTW-1:0]    col_inc;
    logic               row_end;
    logic [CW-1:0]      ptr_eff;
    logic [CNTW-1:0]    ptr_inc;
    logic               last_row;

    assign cmd_ready = !s1_valid_reg || !fifo_status.full;
    assign accept    = cmd_valid && cmd_ready;
    assign is_load   = accept && (cmd_word.command == mvm_pkg::CMD_LOAD);
    assign is_matrix = accept && (cmd_word.command == mvm_pkg::CMD_MATRIX);
    assign push      = s1_valid_reg && !fifo_status.full;

    always_comb
    begin
        // restart a stale index if the column count shrank
        col_eff  = (CNTW'(col_reg) >= cols) ? '0 : col_reg;
        col_inc  = CNTW'(col_eff) + CNTW'(1);
        row_end  = (col_inc >= cols);
        ptr_eff  = (CNTW'(ptr_reg) >= cols) ? '0 : ptr_reg;
        ptr_inc  = CNTW'(ptr_eff) + CNTW'(1);
        last_row = (RNTW'(row_reg) >= (rows - RNTW'(1)));

        col_next      = col_reg;
        ptr_next      = ptr_reg;
        row_next      = row_reg;
        fresh_next    = fresh_reg;
        s1_valid_next = push ? 1'b0 : s1_valid_reg;

        if (is_load)
        begin
            ptr_next   = (ptr_inc >= cols) ? '0 : ptr_inc[CW-1:0];
            col_next   = '0;
            fresh_next = 1'b1;
        end
        else if (is_matrix)
        begin
            s1_valid_next = 1'b1;
            fresh_next    = row_end;
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            ptr_reg      <= '0;
            row_reg      <= '0;
            fresh_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            ptr_reg      <= ptr_next;
            row_reg      <= row_next;
            fresh_reg    <= fresh_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // vector store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            vec_mem[ptr_eff] <= cmd_word.value;
        end
        if (is_matrix)
        begin
            vec_reg <= vec_mem[col_eff];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_matrix)
        begin
            s1_reg.value      <= cmd_word.value;
            s1_reg.vec        <= '0;
            s1_reg.first      <= fresh_reg;
            s1_reg.row_end    <= row_end;
            s1_reg.last_row   <= last_row;
            s1_reg.row_number <= mvm_pkg::ROW_NUM_W'(row_reg);
        end
    end

    always_comb
    begin
        push_word     = s1_reg;
        push_word.vec = vec_reg;
    end

endmodule

FILE: rtl/core/mvm_fifo.sv
module mvm_fifo #(
    parameter int DEPTH = mvm_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mvm_pkg::mac_word_t    push_word,
    input  logic                  pop,
    output mvm_pkg::mac_word_t    pop_word,
    output mvm_pkg::fifo_status_t status
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);

    mvm_pkg::mac_word_t slot_reg [DEPTH];
    logic [PW-1:0]      wr_reg, wr_next;
    logic [PW-1:0]      rd_reg, rd_next;
    logic [NW-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_next    = push ? ((wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + PW'(1)) : wr_reg;
        rd_next    = pop  ? ((rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + PW'(1)) : rd_reg;
        count_next = count_reg + NW'(push) - NW'(pop);
    end

    assign status.full  = (count_reg == NW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_word     = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/core/mvm_back.sv
module mvm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mvm_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    input  mvm_pkg::mac_word_t    pop_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mvm_pkg::res_word_t    res_word
);

    localparam logic signed [47:0] ROW_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ROW_MIN = 48'sh8000_0000_0000;
    localparam logic signed [55:0] SUM_MAX = 56'sh7F_FFFF_FFFF_FFFF;
    localparam logic signed [55:0] SUM_MIN = 56'sh80_0000_0000_0000;

    // product stage
    logic                 p_valid_reg, p_valid_next;
    logic signed [31:0]   p_prod_reg;
    logic                 p_first_reg;
    logic                 p_row_end_reg;
    logic                 p_last_reg;
    logic [mvm_pkg::ROW_NUM_W-1:0] p_row_reg;

    // row accumulator and finished-row stage
    logic signed [47:0]   acc_reg;
    logic                 r_valid_reg, r_valid_next;
    logic signed [47:0]   r_sum_reg;
    logic                 r_last_reg;
    logic [mvm_pkg::ROW_NUM_W-1:0] r_row_reg;

    // checksum and output word
    logic signed [55:0]   chk_reg, chk_next;
    logic                 res_valid_reg, res_valid_next;
    mvm_pkg::res_word_t   res_word_reg;

    logic                 out_free;
    logic                 r_free;
    logic                 acc_take;
    logic                 p_free;
    logic                 r_move;
    logic signed [47:0]   acc_base;
    logic signed [48:0]   acc_sum;
    logic signed [47:0]   acc_sat;
    logic signed [56:0]   chk_sum;
    logic signed [55:0]   chk_sat;

    assign out_free = !res_valid_reg || res_ready;
    assign r_free   = !r_valid_reg || out_free;
    assign r_move   = r_valid_reg && out_free;
    assign acc_take = p_valid_reg && (!p_row_end_reg || r_free);
    assign p_free   = !p_valid_reg || acc_take;
    assign pop      = !fifo_status.empty && p_free;

    always_comb
    begin
        acc_base = p_first_reg ? '0 : acc_reg;
        acc_sum  = 49'(acc_base) + 49'(p_prod_reg);
        if (acc_sum[48] != acc_sum[47])
        begin
            acc_sat = acc_sum[48] ? ROW_MIN : ROW_MAX;
        end
        else
        begin
            acc_sat = acc_sum[47:0];
        end

        chk_sum = 57'(chk_reg) + 57'(r_sum_reg);
        if (chk_sum[56] != chk_sum[55])
        begin
            chk_sat = chk_sum[56] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            chk_sat = chk_sum[55:0];
        end

        p_valid_next = pop ? 1'b1 : (acc_take ? 1'b0 : p_valid_reg);

        r_valid_next = r_move ? 1'b0 : r_valid_reg;
        if (acc_take && p_row_end_reg)
        begin
            r_valid_next = 1'b1;
        end

        res_valid_next = (res_valid_reg && res_ready) ? 1'b0 : res_valid_reg;
        chk_next       = chk_reg;
        if (r_move)
        begin
            res_valid_next = 1'b1;
            chk_next       = r_last_reg ? '0 : chk_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            chk_reg       <= '0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            r_valid_reg   <= r_valid_next;
            res_valid_reg <= res_valid_next;
            chk_reg       <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_prod_reg    <= 32'(pop_word.value) * 32'(pop_word.vec);
            p_first_reg   <= pop_word.first;
            p_row_end_reg <= pop_word.row_end;
            p_last_reg    <= pop_word.last_row;
            p_row_reg     <= pop_word.row_number;
        end
        if (acc_take)
        begin
            acc_reg <= acc_sat;
        end
        if (acc_take && p_row_end_reg)
        begin
            r_sum_reg  <= acc_sat;
            r_last_reg <= p_last_reg;
            r_row_reg  <= p_row_reg;
        end
        if (r_move)
        begin
            res_word_reg.row_sum          <= r_sum_reg;
            res_word_reg.row_number       <= r_row_reg;
            res_word_reg.last_row         <= r_last_reg;
            res_word_reg.running_checksum <= chk_sat;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

FILE: rtl/core/matrix_vector_multiply.sv
// A row-closing word passes the front, queue, product, finished-row and output registers.
// Throughput: one word (load or matrix) per cycle while the queue has room; one vector store
//   port and one 16x16 multiplier set this, with row and checksum adds in stages of their own.
// Reset: rst_n clears all counters, the checksum and every valid flag at once; the vector
//   store is not cleared and holds garbage until loaded. No clearing pass after reset.
module matrix_vector_multiply #(
    parameter int MAX_COLS = mvm_pkg::DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = mvm_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input words
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  mvm_pkg::cmd_word_t               cmd_word,
    // result words
    output logic                             res_valid,
    input  logic                             res_ready,
    output mvm_pkg::res_word_t               res_word,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNTW = $clog2(MAX_COLS+1);
    localparam int RNTW = $clog2(MAX_ROWS+1);

    logic [mvm_pkg::CFG_DATA_W-1:0] num_cols_reg, num_cols_next;
    logic [mvm_pkg::CFG_DATA_W-1:0] num_rows_reg, num_rows_next;

    logic [CNTW-1:0]        cols;
    logic [RNTW-1:0]        rows;
    logic                   cfg_write;

    logic                   push;
    logic                   pop;
    mvm_pkg::mac_word_t     push_word;
    mvm_pkg::mac_word_t     pop_word;
    mvm_pkg::fifo_status_t  fifo_status;

    // Configuration is always taken; decode the register index.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        num_cols_next = num_cols_reg;
        num_rows_next = num_rows_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mvm_pkg::REG_NUM_COLS: num_cols_next = cfg_data;
                mvm_pkg::REG_NUM_ROWS: num_rows_next = cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= mvm_pkg::RESET_COUNT;
            num_rows_reg <= mvm_pkg::RESET_COUNT;
        end
        else
        begin
            num_cols_reg <= num_cols_next;
            num_rows_reg <= num_rows_next;
        end
    end

    // Clamp the counts in use: zero acts as one, anything above the
    // parameter acts as the parameter.
    always_comb
    begin
        if (num_cols_reg == '0)
        begin
            cols = CNTW'(1);
        end
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
        begin
            cols = CNTW'(MAX_COLS);
        end
        else
        begin
            cols = CNTW'(num_cols_reg);
        end

        if (num_rows_reg == '0)
        begin
            rows = RNTW'(1);
        end
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
        begin
            rows = RNTW'(MAX_ROWS);
        end
        else
        begin
            rows = RNTW'(num_rows_reg);
        end
    end

    // Front: accept words, keep the vector store and the column/row counters,
    // and fetch the vector element for each matrix word.
    mvm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_word    (cmd_word),
        .cols        (cols),
        .rows        (rows),
        .fifo_status (fifo_status),
        .push        (push),
        .push_word   (push_word)
    );

    // Short queue so a stalled result does not stop the front at once.
    mvm_fifo #(
        .DEPTH (mvm_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .status    (fifo_status)
    );

    // Back: multiply, saturating row accumulate, saturating checksum, output word.
    mvm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_status (fifo_status),
        .pop         (pop),
        .pop_word    (pop_word),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_word    (res_word)
    );

`ifndef SYNTHESIS
    a_fifo_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_status.full && fifo_status.empty))
        else $error("queue reports full and empty together");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> !fifo_status.empty)
        else $error("input stalled with an empty queue");

    a_cols_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == mvm_pkg::REG_NUM_COLS) |=> num_cols_reg == $past(cfg_data))
        else $error("column count write lost");
`endif

endmodule
